@@ rtl/assert_macros.svh @@
// Assertion macros shared by the biquad RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define BBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/bbl_pkg.sv @@
// Types, constants, microcode ROM and rounding helper of the biquad low-pass.
// No dependencies; used by bbl_seq, bbl_dp and the top level.
package bbl_pkg;

   localparam int COEF_W  = 32;
   localparam int STATE_W = 32;
   localparam int PROD_W  = 64;
   localparam int SUM_W   = 35;
   localparam int SPLIT_W = 16;
   localparam int Q_FRAC  = 30;
   localparam int Y_ACC_W = 68;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2       = 2'd3;

   typedef logic [2:0] step_type;

   localparam step_type STEP_FETCH = 3'd0;
   localparam step_type STEP_FB1   = 3'd1;
   localparam step_type STEP_FB2   = 3'd2;
   localparam step_type STEP_SUM   = 3'd3;
   localparam step_type STEP_MHI   = 3'd4;
   localparam step_type STEP_MLO   = 3'd5;
   localparam step_type STEP_OUT   = 3'd6;
   localparam step_type STEP_PASS  = 3'd7;

   typedef enum logic [1:0] {MUL_A_A1, MUL_A_A2, MUL_A_B0} mul_a_type;
   typedef enum logic [1:0] {MUL_B_W1, MUL_B_W2, MUL_B_SH, MUL_B_SL} mul_b_type;
   typedef enum logic [2:0] {
      DP_NONE, DP_SUB1, DP_SUB2, DP_SUM, DP_YHI, DP_EMIT_Y, DP_EMIT_RAW
   } dp_op_type;
   typedef enum logic [1:0] {SEQ_NEXT, SEQ_FETCH, SEQ_EMIT} seq_op_type;

   typedef struct packed {
      seq_op_type seq_op;
      step_type   target;
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      dp_op_type  dp_op;
   } ucode_type;

   typedef struct packed {
      mul_a_type mul_a;
      mul_b_type mul_b;
      dp_op_type op;
      logic      load;
      logic      emit;
   } dp_ctrl_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

   // Control store: one word per step.
   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      unique case (s)
         STEP_FETCH: w = '{SEQ_FETCH, STEP_PASS,  MUL_A_A1, MUL_B_W1, DP_NONE};
         STEP_FB1:   w = '{SEQ_NEXT,  STEP_FETCH, MUL_A_A2, MUL_B_W2, DP_SUB1};
         STEP_FB2:   w = '{SEQ_NEXT,  STEP_FETCH, MUL_A_A1, MUL_B_W1, DP_SUB2};
         STEP_SUM:   w = '{SEQ_NEXT,  STEP_FETCH, MUL_A_A1, MUL_B_W1, DP_SUM};
         STEP_MHI:   w = '{SEQ_NEXT,  STEP_FETCH, MUL_A_B0, MUL_B_SH, DP_NONE};
         STEP_MLO:   w = '{SEQ_NEXT,  STEP_FETCH, MUL_A_B0, MUL_B_SL, DP_YHI};
         STEP_OUT:   w = '{SEQ_EMIT,  STEP_FETCH, MUL_A_B0, MUL_B_SL, DP_EMIT_Y};
         STEP_PASS:  w = '{SEQ_EMIT,  STEP_FETCH, MUL_A_A1, MUL_B_W1, DP_EMIT_RAW};
         default:    w = '{SEQ_NEXT,  STEP_FETCH, MUL_A_A1, MUL_B_W1, DP_NONE};
      endcase
      return w;
   endfunction

   // Round a Q2.30 by state product back to the state format, half up.
   function automatic logic signed [PROD_W-Q_FRAC-1:0] round_q30(logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + (PROD_W'(1) <<< (Q_FRAC - 1));
      return t[PROD_W-1:Q_FRAC];
   endfunction

endpackage

@@ rtl/butterworth_biquad_lowpass_unit.sv @@
// Second-order low-pass biquad (direct form II), microcoded.
// Upstream: request beat req_sample_in on req_valid/req_ready; downstream: response
// beat rsp_sample_out/rsp_guard_hit on rsp_valid/rsp_ready; csr_* writes the
// enable bit and the Q2.30 coefficients b0, a1, a2 (write only when idle).
// A filtered sample runs the fetch, two feedback, sum, high and low product and
// output steps in order; a pass-through sample (filter disabled) runs fetch and
// its output step only. The control program runs the four coefficient products
// through one shared 32x32 multiplier; a new request is taken only at the fetch
// step, after the last sample has been emitted.
// The output register holds one finished beat; the sequencer waits at its
// output step while that beat is stalled, so req_ready stays low until the
// receiver takes it. A new request is taken while the last response still waits.
// Reset clears the delay line, the coefficients and the enable bit, empties the
// output register and returns the step counter to the fetch step.
// Depends on bbl_pkg, bbl_seq, bbl_dp and assert_macros.svh.
`include "assert_macros.svh"

module butterworth_biquad_lowpass_unit #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int STATE_FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_guard_hit,
   input  logic                           csr_write_en,
   input  logic [bbl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbl_pkg::COEF_W-1:0]     csr_wdata
);
   import bbl_pkg::*;

   // configuration registers
   logic                     filter_enable_ff;
   logic signed [COEF_W-1:0] coef_b0_ff, coef_a1_ff, coef_a2_ff;

   dp_ctrl_type ctrl;
   dp_stat_type stat;
   step_type    step;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b0;
         coef_b0_ff       <= '0;
         coef_a1_ff       <= '0;
         coef_a2_ff       <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FILTER_ENABLE: filter_enable_ff <= csr_wdata[0];
            CSR_COEF_B0:       coef_b0_ff       <= csr_wdata;
            CSR_COEF_A1:       coef_a1_ff       <= csr_wdata;
            CSR_COEF_A2:       coef_a2_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // step counter and control store
   bbl_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .filter_enable (filter_enable_ff),
      .stat          (stat),
      .ctrl          (ctrl),
      .step          (step)
   );

   // arithmetic, delay line and output register
   bbl_dp #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .sample_in      (req_sample_in),
      .coef_b0        (coef_b0_ff),
      .coef_a1        (coef_a1_ff),
      .coef_a2        (coef_a2_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_guard_hit  (rsp_guard_hit)
   );

   // a beat is written into the output register only when it is free
   `BBL_ASSERT_IMPL(a_emit_slot_free, clock, reset, ctrl.emit, stat.out_free)
   // a filtered sample keeps the request side closed on the next cycle
   `BBL_ASSERT_NEXT(a_busy_after_fetch, clock, reset, req_valid && req_ready && filter_enable_ff, !req_ready && step == STEP_FB1)
   // a drained response without a new beat leaves the output empty
   `BBL_ASSERT_NEXT(a_drain_empties, clock, reset, rsp_valid && rsp_ready && !ctrl.emit, !rsp_valid)

endmodule

@@ rtl/bbl_seq.sv @@
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on bbl_pkg.
module bbl_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  filter_enable,
   input  bbl_pkg::dp_stat_type  stat,
   output bbl_pkg::dp_ctrl_type  ctrl,
   output bbl_pkg::step_type     step
);
   import bbl_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;

   assign word = ucode_rom(step_ff);
   assign step = step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      step_in    = step_ff;
      req_ready  = 1'b0;
      ctrl.mul_a = word.mul_a;
      ctrl.mul_b = word.mul_b;
      ctrl.op    = word.dp_op;
      ctrl.load  = 1'b0;
      ctrl.emit  = 1'b0;
      unique case (word.seq_op)
         SEQ_FETCH: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               step_in   = filter_enable ? step_type'(step_ff + 1'b1) : word.target;
            end
         end
         SEQ_EMIT: begin
            // hold until the output register can take the beat
            if (stat.out_free) begin
               ctrl.emit = 1'b1;
               step_in   = word.target;
            end
         end
         SEQ_NEXT: begin
            step_in = step_type'(step_ff + 1'b1);
         end
         default: begin
            step_in = STEP_FETCH;
         end
      endcase
   end

endmodule

@@ rtl/bbl_dp.sv @@
// Datapath: shared 32x32 multiplier, w0/sum/output accumulators, delay line,
// output register. Depends on bbl_pkg; driven by bbl_seq.
module bbl_dp #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int STATE_FRAC_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bbl_pkg::dp_ctrl_type                    ctrl,
   output bbl_pkg::dp_stat_type                    stat,
   input  logic signed [SAMPLE_WIDTH-1:0]          sample_in,
   input  logic signed [bbl_pkg::COEF_W-1:0]       coef_b0,
   input  logic signed [bbl_pkg::COEF_W-1:0]       coef_a1,
   input  logic signed [bbl_pkg::COEF_W-1:0]       coef_a2,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_sample_out,
   output logic                                    rsp_guard_hit
);
   import bbl_pkg::*;

   localparam int XS_W  = SAMPLE_WIDTH + STATE_FRAC_BITS;
   localparam int W0_W  = ((XS_W > 34) ? XS_W : 34) + 2;
   localparam int TOTAL = Q_FRAC + STATE_FRAC_BITS;
   localparam int YSH_W = Y_ACC_W - TOTAL;
   localparam int RND_W = PROD_W - Q_FRAC;

   localparam logic signed [W0_W-1:0] I32_MAX = W0_W'(64'sd2147483647);
   localparam logic signed [W0_W-1:0] I32_MIN = W0_W'(-64'sd2147483648);
   localparam logic signed [Y_ACC_W-1:0] Y_RND = Y_ACC_W'(1) <<< (TOTAL - 1);
   localparam logic signed [YSH_W-1:0] S_MAX = YSH_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [YSH_W-1:0] S_MIN = YSH_W'(-(1 << (SAMPLE_WIDTH - 1)));

   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [STATE_W-1:0]      w1_ff, w2_ff;
   logic signed [W0_W-1:0]         w0_ff, w0_in;
   logic                           guard_ff, guard_in;
   logic signed [SUM_W-1:0]        s_ff, s_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [PROD_W-1:0]       yacc_ff, yacc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] out_ff;
   logic                           out_guard_ff;

   logic signed [COEF_W-1:0]       mul_a;
   logic signed [STATE_W-1:0]      mul_b;
   logic signed [W0_W-1:0]         xs, w0_next;
   logic signed [STATE_W-1:0]      xs_sat;
   logic signed [RND_W-1:0]        prod_rnd;
   logic signed [Y_ACC_W-1:0]      y_full;
   logic signed [YSH_W-1:0]        y_sh;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;

   // multiplier operand selection
   always_comb begin
      case (ctrl.mul_a)
         MUL_A_A1: mul_a = coef_a1;
         MUL_A_A2: mul_a = coef_a2;
         MUL_A_B0: mul_a = coef_b0;
         default:  mul_a = coef_a1;
      endcase
      case (ctrl.mul_b)
         MUL_B_W1: mul_b = w1_ff;
         MUL_B_W2: mul_b = w2_ff;
         MUL_B_SH: mul_b = STATE_W'($signed(s_ff[SUM_W-1:SPLIT_W]));
         MUL_B_SL: mul_b = STATE_W'({1'b0, s_ff[SPLIT_W-1:0]});
         default:  mul_b = w1_ff;
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_rnd = round_q30(prod_ff);

   assign xs      = W0_W'(x_ff) <<< STATE_FRAC_BITS;
   assign xs_sat  = (xs > I32_MAX) ? STATE_W'(I32_MAX) :
                    (xs < I32_MIN) ? STATE_W'(I32_MIN) : xs[STATE_W-1:0];
   assign w0_next = w0_ff - W0_W'(prod_rnd);

   assign y_full = (Y_ACC_W'(yacc_ff) <<< SPLIT_W) + Y_ACC_W'(prod_ff) + Y_RND;
   assign y_sh   = y_full[Y_ACC_W-1:TOTAL];
   assign y_sat  = (y_sh > S_MAX) ? S_MAX[SAMPLE_WIDTH-1:0] :
                   (y_sh < S_MIN) ? S_MIN[SAMPLE_WIDTH-1:0] : y_sh[SAMPLE_WIDTH-1:0];

   always_comb begin
      w0_in    = w0_ff;
      guard_in = guard_ff;
      s_in     = s_ff;
      yacc_in  = yacc_ff;
      unique case (ctrl.op)
         DP_SUB1: w0_in = xs - W0_W'(prod_rnd);
         DP_SUB2: begin
            // overflow guard: fall back to the scaled sample
            if (w0_next > I32_MAX || w0_next < I32_MIN) begin
               w0_in    = W0_W'(xs_sat);
               guard_in = 1'b1;
            end else begin
               w0_in    = w0_next;
               guard_in = 1'b0;
            end
         end
         DP_SUM: s_in = SUM_W'($signed(w0_ff[STATE_W-1:0])) + (SUM_W'(w1_ff) <<< 1)
                        + SUM_W'(w2_ff);
         DP_YHI: yacc_in = prod_ff;
         DP_NONE, DP_EMIT_Y, DP_EMIT_RAW: ;
         default: ;
      endcase
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in  = ctrl.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         w1_ff        <= '0;
         w2_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.emit && ctrl.op == DP_EMIT_Y) begin
            w2_ff <= w1_ff;
            w1_ff <= w0_ff[STATE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      w0_ff    <= w0_in;
      guard_ff <= guard_in;
      s_ff     <= s_in;
      yacc_ff  <= yacc_in;
      if (ctrl.load) begin
         x_ff <= sample_in;
      end
      if (ctrl.emit) begin
         out_ff       <= (ctrl.op == DP_EMIT_Y) ? y_sat : x_ff;
         out_guard_ff <= (ctrl.op == DP_EMIT_Y) ? guard_ff : 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;
   assign rsp_guard_hit  = out_guard_ff;

endmodule
